FILE: hw/rtl/morse_key_timing_decoder_macros.svh
// assertion helpers for the morse key timing decoder
`ifndef MORSE_KEY_TIMING_DECODER_MACROS_SVH
`define MORSE_KEY_TIMING_DECODER_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define MKTD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the antecedent
`define MKTD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mktd_pkg.sv
package mktd_pkg;

   // counter width default and the width of the timeout product
   localparam int COUNT_WIDTH_DEFAULT = 18;
   localparam int UNIT_WIDTH          = 12;
   localparam int GLITCH_WIDTH        = 8;
   localparam int TIMEOUT_WIDTH       = 6;
   localparam int PROD_WIDTH          = UNIT_WIDTH + TIMEOUT_WIDTH;

   // register reset values
   localparam logic [UNIT_WIDTH-1:0]    UNIT_TICKS_RESET    = 12'd100;
   localparam logic [GLITCH_WIDTH-1:0]  GLITCH_TICKS_RESET  = 8'd25;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_UNITS_RESET = 6'd10;

   // csr bus geometry
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // cut-offs as cross-multiples: 0.3 unit is 10*d >= 3*u, 1.5 unit is 2*d > 3*u
   localparam int SHORT_RUN_SCALE = 10;
   localparam int UNIT_SCALE      = 3;
   localparam int LONG_RUN_SCALE  = 2;
   localparam int WORD_GAP_UNITS  = 4;

   // stream widths
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   typedef enum logic [1:0] {
      REG_UNIT_TICKS    = 2'd0,
      REG_GLITCH_TICKS  = 2'd1,
      REG_TIMEOUT_UNITS = 2'd2
   } reg_idx_type;

   typedef enum logic [1:0] {
      SYM_DOT    = 2'd0,
      SYM_DASH   = 2'd1,
      SYM_LETTER = 2'd2,
      SYM_WORD   = 2'd3
   } sym_type;

   typedef struct packed {
      logic [UNIT_WIDTH-1:0]    unit_ticks;
      logic [GLITCH_WIDTH-1:0]  glitch_ticks;
      logic [TIMEOUT_WIDTH-1:0] timeout_units;
   } cfg_type;

   typedef struct packed {
      logic    symbol_valid;
      sym_type symbol;
      logic    message_done;
   } rsp_type;

   typedef struct packed {
      logic started;
      logic step;
   } core_status_type;

endpackage

FILE: hw/rtl/mktd_csr.sv
module mktd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mktd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [mktd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [mktd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output mktd_pkg::cfg_type                     cfg
);

   mktd_pkg::cfg_type     cfg_ff;
   mktd_pkg::cfg_type     cfg_in;
   mktd_pkg::reg_idx_type reg_idx;
   logic                  write_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = mktd_pkg::reg_idx_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_idx)
            mktd_pkg::REG_UNIT_TICKS: begin
               cfg_in.unit_ticks = csr_pwdata[mktd_pkg::UNIT_WIDTH-1:0];
            end
            mktd_pkg::REG_GLITCH_TICKS: begin
               cfg_in.glitch_ticks = csr_pwdata[mktd_pkg::GLITCH_WIDTH-1:0];
            end
            mktd_pkg::REG_TIMEOUT_UNITS: begin
               cfg_in.timeout_units = csr_pwdata[mktd_pkg::TIMEOUT_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         mktd_pkg::REG_UNIT_TICKS: begin
            csr_prdata = mktd_pkg::CSR_DATA_WIDTH'(cfg_ff.unit_ticks);
         end
         mktd_pkg::REG_GLITCH_TICKS: begin
            csr_prdata = mktd_pkg::CSR_DATA_WIDTH'(cfg_ff.glitch_ticks);
         end
         mktd_pkg::REG_TIMEOUT_UNITS: begin
            csr_prdata = mktd_pkg::CSR_DATA_WIDTH'(cfg_ff.timeout_units);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_ticks    <= mktd_pkg::UNIT_TICKS_RESET;
         cfg_ff.glitch_ticks  <= mktd_pkg::GLITCH_TICKS_RESET;
         cfg_ff.timeout_units <= mktd_pkg::TIMEOUT_UNITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/mktd_core.sv
module mktd_core #(
   parameter int COUNT_WIDTH = mktd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mktd_pkg::cfg_type           cfg,
   input  logic                        step,
   input  logic                        level,
   output mktd_pkg::rsp_type           result,
   output mktd_pkg::core_status_type   status
);

   // compare width covers 10*d as well as 3*u and 4*u
   localparam int CMP_WIDTH  = COUNT_WIDTH + 4;
   localparam int DONE_WIDTH = (COUNT_WIDTH > mktd_pkg::PROD_WIDTH) ?
                               COUNT_WIDTH : mktd_pkg::PROD_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic                             started_ff, started_in;
   logic                             prev_level_ff, prev_level_in;
   logic [COUNT_WIDTH-1:0]           run_ticks_ff, run_ticks_in;
   logic [COUNT_WIDTH-1:0]           elapsed;
   logic [CMP_WIDTH-1:0]             d_wide, u_wide;
   logic                             past_short, is_long, is_word, past_glitch;
   logic [mktd_pkg::PROD_WIDTH-1:0]  timeout_ticks;

   // saturating run length including this tick
   assign elapsed = (run_ticks_ff == COUNT_MAX) ? run_ticks_ff : run_ticks_ff + 1'b1;

   // cut-off compares as integer cross-multiples
   assign d_wide      = CMP_WIDTH'(elapsed);
   assign u_wide      = CMP_WIDTH'(cfg.unit_ticks);
   assign past_short  = (d_wide * CMP_WIDTH'(mktd_pkg::SHORT_RUN_SCALE)) >=
                        (u_wide * CMP_WIDTH'(mktd_pkg::UNIT_SCALE));
   assign is_long     = (d_wide * CMP_WIDTH'(mktd_pkg::LONG_RUN_SCALE)) >
                        (u_wide * CMP_WIDTH'(mktd_pkg::UNIT_SCALE));
   assign is_word     = d_wide > (u_wide * CMP_WIDTH'(mktd_pkg::WORD_GAP_UNITS));
   assign past_glitch = elapsed > COUNT_WIDTH'(cfg.glitch_ticks);

   assign timeout_ticks = mktd_pkg::PROD_WIDTH'(cfg.timeout_units) *
                          mktd_pkg::PROD_WIDTH'(cfg.unit_ticks);

   // run tracking and classification of the run that ends
   always_comb begin
      started_in          = started_ff;
      prev_level_in       = prev_level_ff;
      run_ticks_in        = run_ticks_ff;
      result.symbol_valid = 1'b0;
      result.symbol       = mktd_pkg::SYM_DOT;
      if (step) begin
         if (!started_ff) begin
            if (level) begin
               started_in    = 1'b1;
               prev_level_in = 1'b1;
               run_ticks_in  = '0;
            end
         end else if (level != prev_level_ff) begin
            if (past_glitch && past_short) begin
               if (prev_level_ff) begin
                  result.symbol_valid = 1'b1;
                  result.symbol       = is_long ? mktd_pkg::SYM_DASH : mktd_pkg::SYM_DOT;
               end else if (is_long) begin
                  result.symbol_valid = 1'b1;
                  result.symbol       = is_word ? mktd_pkg::SYM_WORD : mktd_pkg::SYM_LETTER;
               end
            end
            prev_level_in = level;
            run_ticks_in  = '0;
         end else begin
            run_ticks_in = elapsed;
         end
      end
      result.message_done = started_in &&
                            (DONE_WIDTH'(run_ticks_in) >= DONE_WIDTH'(timeout_ticks));
   end

   assign status.started = started_ff;
   assign status.step    = step;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         prev_level_ff <= 1'b0;
         run_ticks_ff  <= '0;
      end else begin
         started_ff    <= started_in;
         prev_level_ff <= prev_level_in;
         run_ticks_ff  <= run_ticks_in;
      end
   end

endmodule

FILE: hw/rtl/mktd_out_stage.sv
module mktd_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mktd_pkg::rsp_type  push_data,
   output logic               push_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output mktd_pkg::rsp_type  out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   mktd_pkg::rsp_type main_ff, main_in;
   mktd_pkg::rsp_type skid_ff, skid_in;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   // output register with a skid entry behind it
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         main_valid_in = skid_valid_ff || push;
         main_in       = skid_valid_ff ? skid_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: hw/rtl/morse_key_timing_decoder.sv
// Morse key timing decoder. One sampled key level enters per transfer on the req
// stream and exactly one result leaves on the rsp stream for each. The block accepts
// one item every cycle: the run counter and its cut-off compares are combinational,
// so only the rsp side stalling slows it. An item sits in the input register, is
// classified by the core into the output register (or the skid entry while the
// output is held) and leaves from there; the skid entry lets the input take one
// more item after rsp_tready drops. The user must write configuration over the csr
// port only while no items are in flight; the block itself does not enforce it.
`include "morse_key_timing_decoder_macros.svh"

module morse_key_timing_decoder #(
   parameter int COUNT_WIDTH = mktd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [0] level, upper bits zero
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mktd_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // rsp_tdata: [1:0] symbol, [2] message_done, upper bits zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mktd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // rsp_tuser: [0] symbol_valid
   output logic                                  rsp_tuser,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mktd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [mktd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [mktd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   mktd_pkg::cfg_type         cfg;
   mktd_pkg::rsp_type         core_result;
   mktd_pkg::rsp_type         out_data;
   mktd_pkg::core_status_type core_status;
   logic                      in_valid_ff, in_valid_in;
   logic                      in_level_ff, in_level_in;
   logic                      stage_ready;
   logic                      advance;

   // input register
   assign advance    = in_valid_ff && stage_ready;
   assign req_tready = !in_valid_ff || stage_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_level_in = in_level_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_level_in = req_tdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_level_ff <= in_level_in;
   end

   mktd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mktd_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .level  (in_level_ff),
      .result (core_result),
      .status (core_status)
   );

   mktd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .push       (advance),
      .push_data  (core_result),
      .push_ready (stage_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   // result packing
   assign rsp_tuser = out_data.symbol_valid;
   assign rsp_tdata = mktd_pkg::RSP_DATA_WIDTH'({out_data.message_done, out_data.symbol});

   // checks
   `MKTD_ASSERT_NOW(a_idle_symbol_zero, rsp_tvalid && !rsp_tuser, rsp_tdata[1:0] == mktd_pkg::SYM_DOT, "symbol not zero without a decode")
   `MKTD_ASSERT_NEXT(a_started_sticks, core_status.started, core_status.started, "decoder left the started state")
   `MKTD_ASSERT_NEXT(a_done_needs_start, core_status.step && core_result.message_done, core_status.started, "message done before the first mark")
   `MKTD_ASSERT_NOW(a_symbol_needs_start, core_status.step && core_result.symbol_valid, core_status.started, "symbol decoded before the first mark")

endmodule
